/* design/iad_pkg.sv */
// Shared types, constants and elaboration-time tables for the air density block.
// Holds the log2 and exp2 tables, the layer constants and the queue word type.
// Has no dependencies.
package iad_pkg;

   // Build-time precision settings.
   localparam int DENSITY_FRAC_BITS   = 30;
   localparam int LOG_EXP_TABLE_DEPTH = 256;

   // Field and datapath widths.
   localparam int IDX_W       = $clog2(LOG_EXP_TABLE_DEPTH + 1);
   localparam int FRAC_W      = 30;
   localparam int ALT_W       = 21;
   localparam int DENS_W      = 31;
   localparam int LAYER_W     = 2;
   localparam int HGT_W       = 19;
   localparam int DH_W        = 18;
   localparam int TEMP_W      = 25;
   localparam int RT_W        = 44;
   localparam int EXPO_W      = 6;
   localparam int LOG_W       = EXPO_W + FRAC_W;
   localparam int TAB_W       = 32;
   localparam int N_W         = 30;
   localparam int COEF_W      = 29;
   localparam int ISO_W       = COEF_W + DH_W;
   localparam int V_W         = 40;
   localparam int IP_W        = V_W - FRAC_W;
   localparam int SHIFT_W     = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int LOG_LAT     = 5;

   // Layer codes.
   localparam logic [LAYER_W-1:0] LAYER_TROPO  = 2'd0;
   localparam logic [LAYER_W-1:0] LAYER_ISO    = 2'd1;
   localparam logic [LAYER_W-1:0] LAYER_STRAT1 = 2'd2;
   localparam logic [LAYER_W-1:0] LAYER_STRAT2 = 2'd3;

   // Physical constants in scaled integer form.
   localparam logic [63:0] ONE_Q30   = 64'd1073741824;
   localparam logic [63:0] MASK_Q30  = 64'd1073741823;
   localparam logic [63:0] G_E5      = 64'd980665;
   localparam logic [63:0] R_E3      = 64'd287058;
   localparam logic [63:0] P0_PA     = 64'd101325;
   localparam logic [63:0] LOG2E_Q30 = 64'd1549082005;
   localparam logic [63:0] SCALE_E8  = 64'd100000000;
   localparam logic [63:0] TB0_E5    = 64'd28815000;
   localparam logic [63:0] TB1_E5    = 64'd21665000;
   localparam logic [63:0] TB3_E5    = 64'd22865000;
   localparam logic [63:0] DEPTH64   = 64'(LOG_EXP_TABLE_DEPTH);

   localparam logic [DENS_W-1:0] OUT_MAX = '1;

   typedef logic [TAB_W-1:0] table_type [LOG_EXP_TABLE_DEPTH+1];

   // Word that the front hands to the back through the queue.
   typedef struct packed {
      logic [LAYER_W-1:0] layer;
      logic               clamped;
      logic [DH_W-1:0]    dh;
      logic [TEMP_W-1:0]  temp;
   } item_type;

   // Result-side tag that travels along the back pipeline.
   typedef struct packed {
      logic [LAYER_W-1:0] layer;
      logic               clamped;
   } tag_type;

   // Bitwise log2 of a Q30 mantissa in [1,2) by repeated squaring.
   function automatic logic [63:0] log_frac_exact(input logic [63:0] m_in);
      logic [63:0] m;
      logic [63:0] r;
      m = m_in;
      r = 64'd0;
      for (int b = 29; b >= 0; b--) begin
         m = (m * m) >> 30;
         if (m >= 2 * ONE_Q30) begin
            m = m >> 1;
            r = r | (64'd1 << b);
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] log_entry(input logic [63:0] i);
      if (i >= DEPTH64) return ONE_Q30;
      return log_frac_exact(ONE_Q30 + (i << 30) / DEPTH64);
   endfunction

   // Largest Q30 value whose bitwise log2 does not pass the grid point.
   function automatic logic [63:0] exp_entry(input logic [63:0] i);
      logic [63:0] t;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      if (i == 64'd0) return ONE_Q30;
      if (i >= DEPTH64) return 2 * ONE_Q30;
      t  = (i << 30) / DEPTH64;
      lo = ONE_Q30;
      hi = 2 * ONE_Q30 - 64'd1;
      while (lo < hi) begin
         mid = lo + ((hi - lo + 64'd1) >> 1);
         if (log_frac_exact(mid) <= t) lo = mid;
         else hi = mid - 64'd1;
      end
      return lo;
   endfunction

   function automatic table_type make_log_table();
      table_type tbl;
      for (int i = 0; i <= LOG_EXP_TABLE_DEPTH; i++)
         tbl[i] = TAB_W'(log_entry(64'(i)));
      return tbl;
   endfunction

   function automatic table_type make_exp_table();
      table_type tbl;
      for (int i = 0; i <= LOG_EXP_TABLE_DEPTH; i++)
         tbl[i] = TAB_W'(exp_entry(64'(i)));
      return tbl;
   endfunction

   localparam table_type LOG_TABLE = make_log_table();
   localparam table_type EXP_TABLE = make_exp_table();

   // Table-and-interpolation log2 of an integer, same as the hardware unit.
   function automatic logic [63:0] log2_const(input logic [63:0] x);
      logic [63:0] m;
      logic [63:0] p;
      logic [63:0] a;
      logic [63:0] b;
      int e;
      if (x == 64'd0) return 64'd0;
      e = 63;
      while (x[e] == 1'b0) e--;
      m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
      p = (m - ONE_Q30) * DEPTH64;
      a = log_entry(p >> 30);
      b = log_entry((p >> 30) + 64'd1);
      return 64'(e) * ONE_Q30 + a + (((b - a) * (p & MASK_Q30)) >> 30);
   endfunction

   // Per-layer exponents and coefficients.
   localparam logic [63:0] N_Q24_0 = ((G_E5 * 64'd100) << 24) / (R_E3 * 64'd65);
   localparam logic [63:0] N_Q24_2 = ((G_E5 * 64'd100) << 24) / (R_E3 * 64'd10);
   localparam logic [63:0] N_Q24_3 = ((G_E5 * 64'd100) << 24) / (R_E3 * 64'd28);
   localparam logic [63:0] COEF_1  = ((G_E5 * LOG2E_Q30) << 13) / (R_E3 * TB1_E5 / 64'd100);

   localparam logic [63:0] LOG_TB0   = log2_const(TB0_E5);
   localparam logic [63:0] LOG_TB1   = log2_const(TB1_E5);
   localparam logic [63:0] LOG_TB3   = log2_const(TB3_E5);
   localparam logic [63:0] LOG_P0    = log2_const(P0_PA);
   localparam logic [63:0] LOG_SC    = log2_const(SCALE_E8);

   // Pressure drop over each full lower layer, chained into base pressures.
   localparam logic [63:0] DROP0 = (N_Q24_0 * (LOG_TB0 - LOG_TB1)) >> 24;
   localparam logic [63:0] DROP1 = (COEF_1 * 64'd90000) >> 13;
   localparam logic [63:0] DROP2 = (N_Q24_2 * (LOG_TB3 - LOG_TB1)) >> 24;
   localparam logic [63:0] LP1   = LOG_P0 - DROP0;
   localparam logic [63:0] LP2   = LP1 - DROP1;
   localparam logic [63:0] LP3   = LP2 - DROP2;

   localparam logic [HGT_W-1:0] BASE_DM [4] =
      '{19'd0, 19'd110000, 19'd200000, 19'd320000};
   localparam logic signed [ALT_W-1:0] ALT_MAX = 21'sd470000;
   localparam logic [HGT_W-1:0] H_MAX_DM = 19'd470000;
   localparam logic [TEMP_W-1:0] TB_E5 [4] =
      '{25'd28815000, 25'd21665000, 25'd21665000, 25'd22865000};
   localparam logic signed [7:0] LAPSE_E5 [4] = '{-8'sd65, 8'sd0, 8'sd10, 8'sd28};
   localparam logic [LOG_W-1:0] LOG_TB [4] =
      '{LOG_W'(LOG_TB0), LOG_W'(LOG_TB1), LOG_W'(LOG_TB1), LOG_W'(LOG_TB3)};
   localparam logic [LOG_W-1:0] LP_BASE [4] =
      '{LOG_W'(LOG_P0), LOG_W'(LP1), LOG_W'(LP2), LOG_W'(LP3)};
   localparam logic [N_W-1:0] N_Q24 [4] =
      '{N_W'(N_Q24_0), N_W'(0), N_W'(N_Q24_2), N_W'(N_Q24_3)};
   localparam logic [COEF_W-1:0] COEF_Q43 = COEF_W'(COEF_1);
   localparam logic [LOG_W-1:0] LOG_SCALE = LOG_W'(LOG_SC);
   localparam logic [RT_W-1:0] R_CONST = RT_W'(R_E3);
   localparam logic [V_W-1:0] DFB_OFFSET = V_W'(64'(DENSITY_FRAC_BITS) << 30);

endpackage

/* design/iad_front.sv */
// Front end: clamps the altitude, picks the layer and works out the temperature.
// Depends on iad_pkg.
module iad_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [iad_pkg::ALT_W-1:0] req_altitude_dm,
   output logic                           front_valid,
   output iad_pkg::item_type              front_item,
   input  logic                           queue_full
);
   import iad_pkg::*;

   logic                       front_valid_ff;
   item_type                   front_item_ff;
   item_type                   item_in;
   logic                       advance;
   logic [HGT_W-1:0]           h;
   logic [HGT_W-1:0]           dh_full;
   logic                       clamped;
   logic [LAYER_W-1:0]         layer;
   logic signed [TEMP_W+1:0]   temp_s;

   // Clamp into the modeled altitude range.
   always_comb begin
      if (req_altitude_dm[ALT_W-1]) begin
         h       = '0;
         clamped = 1'b1;
      end else if (req_altitude_dm > ALT_MAX) begin
         h       = H_MAX_DM;
         clamped = 1'b1;
      end else begin
         h       = req_altitude_dm[HGT_W-1:0];
         clamped = 1'b0;
      end
   end

   // Layer select by compares against the base heights.
   always_comb begin
      priority if (h >= BASE_DM[3]) layer = LAYER_STRAT2;
      else if (h >= BASE_DM[2])     layer = LAYER_STRAT1;
      else if (h >= BASE_DM[1])     layer = LAYER_ISO;
      else                          layer = LAYER_TROPO;
   end

   // Height above the layer base and the linear temperature.
   always_comb begin
      dh_full = h - BASE_DM[layer];
      temp_s  = $signed({2'b00, TB_E5[layer]})
              + LAPSE_E5[layer] * $signed({1'b0, dh_full});
      item_in.layer   = layer;
      item_in.clamped = clamped;
      item_in.dh      = dh_full[DH_W-1:0];
      item_in.temp    = temp_s[TEMP_W-1:0];
   end

   // The front register moves whenever the queue can take its word.
   assign advance   = !front_valid_ff || !queue_full;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (advance) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         front_item_ff <= item_in;
      end
   end

   assign front_valid = front_valid_ff;
   assign front_item  = front_item_ff;

endmodule

/* design/iad_queue.sv */
// Short FIFO that decouples the front end from the back-end pipeline.
// Depends on iad_pkg.
module iad_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  iad_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              out_valid,
   output iad_pkg::item_type out_item
);
   import iad_pkg::*;

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && out_valid;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // The fill count stays within the depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   // The back end only pops a word that is there.
   assert property (@(posedge clock) disable iff (reset) pop |-> out_valid)
      else $error("pop from empty queue");

   // A lone push grows the fill count by one.
   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

endmodule

/* design/iad_log2.sv */
// Pipelined log2 unit: leading-one detect, normalize, table lookup, interpolation.
// Result is Q30 with the integer exponent above the fraction. Depends on iad_pkg.
module iad_log2 (
   input  logic                       clock,
   input  logic                       advance,
   input  logic [iad_pkg::RT_W-1:0]   x,
   output logic [iad_pkg::LOG_W-1:0]  y
);
   import iad_pkg::*;

   logic [RT_W-1:0]          x1_ff;
   logic [EXPO_W-1:0]        expo1_ff;
   logic [EXPO_W-1:0]        expo_in;
   logic                     zero1_ff;
   logic [RT_W-1:0]          m_norm;
   logic [FRAC_W+IDX_W-1:0]  p;
   logic [IDX_W-1:0]         idx2_ff;
   logic [FRAC_W-1:0]        f2_ff;
   logic [EXPO_W-1:0]        expo2_ff;
   logic                     zero2_ff;
   logic [TAB_W-1:0]         a3_ff;
   logic [TAB_W-1:0]         diff3_ff;
   logic [FRAC_W-1:0]        f3_ff;
   logic [EXPO_W-1:0]        expo3_ff;
   logic                     zero3_ff;
   logic [TAB_W+FRAC_W-1:0]  prod;
   logic [TAB_W-1:0]         a4_ff;
   logic [TAB_W-1:0]         prod4_ff;
   logic [EXPO_W-1:0]        expo4_ff;
   logic                     zero4_ff;
   logic [LOG_W-1:0]         y_ff;

   // Position of the leading one.
   always_comb begin
      expo_in = '0;
      for (int k = 0; k < RT_W; k++) begin
         if (x[k]) expo_in = EXPO_W'(k);
      end
   end

   // Normalize to a mantissa in [1,2) and split off table index and weight.
   always_comb begin
      if (expo1_ff >= EXPO_W'(FRAC_W)) m_norm = x1_ff >> (expo1_ff - EXPO_W'(FRAC_W));
      else m_norm = x1_ff << (EXPO_W'(FRAC_W) - expo1_ff);
      p = {{IDX_W{1'b0}}, m_norm[FRAC_W-1:0]}
        * (FRAC_W+IDX_W)'(LOG_EXP_TABLE_DEPTH);
   end

   assign prod = {{FRAC_W{1'b0}}, diff3_ff} * {{TAB_W{1'b0}}, f3_ff};

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff    <= x;
         expo1_ff <= expo_in;
         zero1_ff <= (x == '0);
         idx2_ff  <= p[FRAC_W +: IDX_W];
         f2_ff    <= p[FRAC_W-1:0];
         expo2_ff <= expo1_ff;
         zero2_ff <= zero1_ff;
         a3_ff    <= LOG_TABLE[idx2_ff];
         diff3_ff <= LOG_TABLE[idx2_ff + 1'b1] - LOG_TABLE[idx2_ff];
         f3_ff    <= f2_ff;
         expo3_ff <= expo2_ff;
         zero3_ff <= zero2_ff;
         a4_ff    <= a3_ff;
         prod4_ff <= prod[TAB_W+FRAC_W-1:FRAC_W];
         expo4_ff <= expo3_ff;
         zero4_ff <= zero3_ff;
         y_ff     <= zero4_ff ? '0
                   : {expo4_ff, {FRAC_W{1'b0}}} + LOG_W'(a4_ff) + LOG_W'(prod4_ff);
      end
   end

   assign y = y_ff;

endmodule

/* design/iad_back.sv */
// Back end: log-domain pressure and density, then the exp2 stage and output register.
// Depends on iad_pkg and iad_log2.
module iad_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  iad_pkg::item_type             q_item,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [iad_pkg::DENS_W-1:0]    rsp_density_q30,
   output logic [iad_pkg::LAYER_W-1:0]   rsp_layer_index,
   output logic                          rsp_altitude_clamped
);
   import iad_pkg::*;

   typedef struct packed {
      logic                neg;
      logic                big;
      logic [SHIFT_W-1:0]  ip;
   } flag_type;

   logic                      adv;
   // Entry stage.
   logic                      b1_valid_ff;
   tag_type                   b1_tag_ff;
   logic [TEMP_W-1:0]         b1_temp_ff;
   logic [RT_W-1:0]           b1_rt_ff;
   logic [ISO_W-1:0]          b1_iso_ff;
   // Side band alongside the log units.
   logic                      sb_valid_ff [LOG_LAT];
   tag_type                   sb_tag_ff [LOG_LAT];
   logic [ISO_W-1:0]          sb_iso_ff [LOG_LAT];
   logic [LOG_W-1:0]          log_t;
   logic [LOG_W-1:0]          log_rt;
   // Pressure stages.
   logic [LOG_W:0]            dlog;
   logic [LOG_W:0]            dabs;
   logic                      b2_valid_ff;
   tag_type                   b2_tag_ff;
   logic [FRAC_W-1:0]         b2_ad_ff;
   logic [LOG_W-1:0]          b2_isod_ff;
   logic [V_W-1:0]            b2_lrt_ff;
   logic [N_W+FRAC_W-1:0]     lapse_prod;
   logic                      b3_valid_ff;
   tag_type                   b3_tag_ff;
   logic [LOG_W-1:0]          b3_drop_ff;
   logic [LOG_W-1:0]          drop_in;
   logic [V_W-1:0]            b3_lrt_ff;
   logic                      b4_valid_ff;
   tag_type                   b4_tag_ff;
   logic [V_W-1:0]            b4_v_ff;
   // Exp2 stages.
   logic [IP_W-1:0]           ip_full;
   logic [FRAC_W+IDX_W-1:0]   ep;
   flag_type                  flag_in;
   logic                      e1_valid_ff;
   tag_type                   e1_tag_ff;
   flag_type                  e1_flag_ff;
   logic [IDX_W-1:0]          e1_idx_ff;
   logic [FRAC_W-1:0]         e1_f_ff;
   logic                      e2_valid_ff;
   tag_type                   e2_tag_ff;
   flag_type                  e2_flag_ff;
   logic [TAB_W-1:0]          e2_a_ff;
   logic [TAB_W-1:0]          e2_diff_ff;
   logic [FRAC_W-1:0]         e2_f_ff;
   logic [TAB_W+FRAC_W-1:0]   eprod;
   logic                      e3_valid_ff;
   tag_type                   e3_tag_ff;
   flag_type                  e3_flag_ff;
   logic [TAB_W-1:0]          e3_a_ff;
   logic [TAB_W-1:0]          e3_prod_ff;
   logic [TAB_W-1:0]          e_sum;
   logic [TAB_W-1:0]          e_shift;
   logic [DENS_W-1:0]         density_in;
   // Output register.
   logic                      rsp_valid_ff;
   tag_type                   rsp_tag_ff;
   logic [DENS_W-1:0]         rsp_density_ff;

   // The whole pipeline moves unless a finished word is held at the output.
   assign adv   = !(rsp_valid_ff && rsp_stall);
   assign q_pop = adv && q_valid;

   // Two log units: one on temperature, one on R times temperature.
   iad_log2 u_log_t (
      .clock   (clock),
      .advance (adv),
      .x       (RT_W'(b1_temp_ff)),
      .y       (log_t)
   );

   iad_log2 u_log_rt (
      .clock   (clock),
      .advance (adv),
      .x       (b1_rt_ff),
      .y       (log_rt)
   );

   // Temperature ratio in the log domain.
   always_comb begin
      dlog = {1'b0, log_t} - {1'b0, LOG_TB[sb_tag_ff[LOG_LAT-1].layer]};
      dabs = dlog[LOG_W] ? -dlog : dlog;
   end

   // Pressure drop: power law in lapse layers, exponential in the isothermal one.
   always_comb begin
      lapse_prod = {{FRAC_W{1'b0}}, N_Q24[b2_tag_ff.layer]} * {{N_W{1'b0}}, b2_ad_ff};
      if (b2_tag_ff.layer == LAYER_ISO) drop_in = b2_isod_ff;
      else drop_in = lapse_prod[N_W+FRAC_W-1:24];
   end

   // Split the scaled log density into integer shift and fraction.
   always_comb begin
      ip_full     = b4_v_ff[V_W-1:FRAC_W];
      flag_in.neg = b4_v_ff[V_W-1];
      flag_in.big = !b4_v_ff[V_W-1] && (ip_full >= IP_W'(31));
      flag_in.ip  = ip_full[SHIFT_W-1:0];
      ep = {{IDX_W{1'b0}}, b4_v_ff[FRAC_W-1:0]}
         * (FRAC_W+IDX_W)'(LOG_EXP_TABLE_DEPTH);
   end

   assign eprod = {{FRAC_W{1'b0}}, e2_diff_ff} * {{TAB_W{1'b0}}, e2_f_ff};

   // Final scaling with saturation.
   always_comb begin
      e_sum = e3_a_ff + e3_prod_ff;
      if (e3_flag_ff.ip == SHIFT_W'(FRAC_W)) e_shift = e_sum;
      else e_shift = e_sum >> (SHIFT_W'(FRAC_W) - e3_flag_ff.ip);
      priority if (e3_flag_ff.neg) density_in = '0;
      else if (e3_flag_ff.big)     density_in = OUT_MAX;
      else if (e_shift[TAB_W-1])   density_in = OUT_MAX;
      else                         density_in = e_shift[DENS_W-1:0];
   end

   // Valid bits of every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         for (int k = 0; k < LOG_LAT; k++) sb_valid_ff[k] <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         b4_valid_ff  <= 1'b0;
         e1_valid_ff  <= 1'b0;
         e2_valid_ff  <= 1'b0;
         e3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         b1_valid_ff    <= q_valid;
         sb_valid_ff[0] <= b1_valid_ff;
         for (int k = 1; k < LOG_LAT; k++) sb_valid_ff[k] <= sb_valid_ff[k-1];
         b2_valid_ff    <= sb_valid_ff[LOG_LAT-1];
         b3_valid_ff    <= b2_valid_ff;
         b4_valid_ff    <= b3_valid_ff;
         e1_valid_ff    <= b4_valid_ff;
         e2_valid_ff    <= e1_valid_ff;
         e3_valid_ff    <= e2_valid_ff;
         rsp_valid_ff   <= e3_valid_ff;
      end
   end

   // Payload of every stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         b1_tag_ff.layer   <= q_item.layer;
         b1_tag_ff.clamped <= q_item.clamped;
         b1_temp_ff        <= q_item.temp;
         b1_rt_ff          <= R_CONST * RT_W'(q_item.temp);
         b1_iso_ff         <= ISO_W'(COEF_Q43) * ISO_W'(q_item.dh);
         sb_tag_ff[0]      <= b1_tag_ff;
         sb_iso_ff[0]      <= b1_iso_ff;
         for (int k = 1; k < LOG_LAT; k++) begin
            sb_tag_ff[k] <= sb_tag_ff[k-1];
            sb_iso_ff[k] <= sb_iso_ff[k-1];
         end
         b2_tag_ff      <= sb_tag_ff[LOG_LAT-1];
         b2_ad_ff       <= dabs[FRAC_W-1:0];
         b2_isod_ff     <= LOG_W'(sb_iso_ff[LOG_LAT-1][ISO_W-1:13]);
         b2_lrt_ff      <= V_W'(log_rt) - V_W'(LOG_SCALE);
         b3_tag_ff      <= b2_tag_ff;
         b3_drop_ff     <= drop_in;
         b3_lrt_ff      <= b2_lrt_ff;
         b4_tag_ff      <= b3_tag_ff;
         b4_v_ff        <= V_W'(LP_BASE[b3_tag_ff.layer]) - V_W'(b3_drop_ff)
                         - b3_lrt_ff + DFB_OFFSET;
         e1_tag_ff      <= b4_tag_ff;
         e1_flag_ff     <= flag_in;
         e1_idx_ff      <= ep[FRAC_W +: IDX_W];
         e1_f_ff        <= ep[FRAC_W-1:0];
         e2_tag_ff      <= e1_tag_ff;
         e2_flag_ff     <= e1_flag_ff;
         e2_a_ff        <= EXP_TABLE[e1_idx_ff];
         e2_diff_ff     <= EXP_TABLE[e1_idx_ff + 1'b1] - EXP_TABLE[e1_idx_ff];
         e2_f_ff        <= e1_f_ff;
         e3_tag_ff      <= e2_tag_ff;
         e3_flag_ff     <= e2_flag_ff;
         e3_a_ff        <= e2_a_ff;
         e3_prod_ff     <= eprod[TAB_W+FRAC_W-1:FRAC_W];
         rsp_tag_ff     <= e3_tag_ff;
         rsp_density_ff <= density_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_density_q30      = rsp_density_ff;
   assign rsp_layer_index      = rsp_tag_ff.layer;
   assign rsp_altitude_clamped = rsp_tag_ff.clamped;

endmodule

/* design/isa_air_density.sv */
// Top level of the standard-atmosphere air density evaluator.
// Depends on iad_pkg, iad_front, iad_queue and iad_back.

// One altitude word in, one density word out, fully pipelined: a new word is
// taken every cycle as long as the result side does not stall. A word passes
// through the front register, the two-entry queue and a 13-stage back pipeline
// (an entry register, two 5-stage log2 units side by side, two pressure stages,
// a density stage and a 4-stage exp2 ending in the output register). A stalled
// result holds the whole back pipeline; the queue then fills and the input
// stalls. The block keeps no state between words and needs no start-up pass.
module isa_air_density (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [iad_pkg::ALT_W-1:0] req_altitude_dm,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [iad_pkg::DENS_W-1:0]       rsp_density_q30,
   output logic [iad_pkg::LAYER_W-1:0]      rsp_layer_index,
   output logic                             rsp_altitude_clamped
);
   import iad_pkg::*;

   logic       front_valid;
   item_type   front_item;
   logic       queue_full;
   logic       q_valid;
   item_type   q_item;
   logic       q_pop;

   // Classification.
   iad_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_altitude_dm (req_altitude_dm),
      .front_valid     (front_valid),
      .front_item      (front_item),
      .queue_full      (queue_full)
   );

   // Decoupling queue.
   iad_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_item  (front_item),
      .full       (queue_full),
      .pop        (q_pop),
      .out_valid  (q_valid),
      .out_item   (q_item)
   );

   // Arithmetic pipeline.
   iad_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_item               (q_item),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_density_q30      (rsp_density_q30),
      .rsp_layer_index      (rsp_layer_index),
      .rsp_altitude_clamped (rsp_altitude_clamped)
   );

endmodule

/* dv/isa_air_density_test.sv */
// Self-checking testbench for the standard-atmosphere air density block.
// Holds a bit-exact density predictor in a scoreboard class; depends on iad_pkg and the RTL.
`timescale 1ns / 1ps

// Scoreboard: predicts density words from altitudes and checks the results in order.
class density_scoreboard;
   typedef struct {
      logic [iad_pkg::DENS_W-1:0]  density;
      logic [iad_pkg::LAYER_W-1:0] layer;
      logic                        clamped;
   } density_word;

   localparam longint unsigned ONE  = 64'd1073741824;
   localparam longint unsigned MASK = 64'd1073741823;
   localparam longint unsigned DEP  = 64'(iad_pkg::LOG_EXP_TABLE_DEPTH);

   longint unsigned log_grid[];
   longint unsigned exp_grid[];
   longint          layer_base[4];
   longint          layer_temp[4];
   longint          layer_lapse[4];
   density_word     awaited[$];
   int              mismatches;
   int              checked;
   int              clamp_seen;
   int              layer_seen[4];

   function new();
      longint unsigned t, lo, hi, mid;
      log_grid = new[iad_pkg::LOG_EXP_TABLE_DEPTH + 1];
      exp_grid = new[iad_pkg::LOG_EXP_TABLE_DEPTH + 1];
      layer_base  = '{0, 110000, 200000, 320000};
      layer_temp  = '{28815000, 21665000, 21665000, 22865000};
      layer_lapse = '{-65, 0, 10, 28};
      for (int i = 0; i <= iad_pkg::LOG_EXP_TABLE_DEPTH; i++) begin
         if (i == iad_pkg::LOG_EXP_TABLE_DEPTH) begin
            log_grid[i] = ONE;
            exp_grid[i] = 2 * ONE;
         end else begin
            t = (longint'(i) << 30) / DEP;
            log_grid[i] = square_log(ONE + t);
            // Search for the largest mantissa whose log does not pass the grid point.
            lo = ONE;
            hi = 2 * ONE - 1;
            if (i == 0) hi = ONE;
            while (lo < hi) begin
               mid = lo + (hi - lo + 1) / 2;
               if (square_log(mid) <= t) lo = mid;
               else hi = mid - 1;
            end
            exp_grid[i] = lo;
         end
      end
   endfunction

   // Bitwise log2 of a Q30 mantissa by repeated squaring.
   function longint unsigned square_log(longint unsigned m_in);
      longint unsigned m, r;
      m = m_in;
      r = 0;
      for (int b = 29; b >= 0; b--) begin
         m = (m * m) >> 30;
         if (m >= 2 * ONE) begin
            m = m >> 1;
            r = r | (64'd1 << b);
         end
      end
      return r;
   endfunction

   // Table log2 of an integer, Q30, with truncating interpolation.
   function longint log2_q30(longint unsigned x);
      longint unsigned m, p, f, a, b;
      int e;
      if (x == 0) return 0;
      e = 63;
      while (x[e] == 1'b0) e--;
      m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
      p = (m - ONE) * DEP;
      f = p & MASK;
      a = log_grid[p >> 30];
      b = log_grid[(p >> 30) + 1];
      return longint'(e) * longint'(ONE) + longint'(a + (((b - a) * f) >> 30));
   endfunction

   // Drop of log2 pressure over dh decimetres of one layer.
   function longint unsigned pressure_drop(int j, longint dh);
      longint unsigned coef, al, n, ad;
      longint d;
      if (layer_lapse[j] == 0) begin
         coef = ((64'd980665 * 64'd1549082005) << 13) / (64'd287058 * 64'(layer_temp[j]) / 100);
         return (coef * 64'(dh)) >> 13;
      end
      al = 64'(layer_lapse[j] < 0 ? -layer_lapse[j] : layer_lapse[j]);
      n  = ((64'd980665 * 64'd100) << 24) / (64'd287058 * al);
      d  = log2_q30(64'(layer_temp[j] + layer_lapse[j] * dh)) - log2_q30(64'(layer_temp[j]));
      ad = 64'(d < 0 ? -d : d);
      return (n * ad) >> 24;
   endfunction

   // Work out the density word for one accepted altitude.
   function void note_altitude(logic signed [iad_pkg::ALT_W-1:0] alt);
      density_word w;
      longint h, dh, lp, lrt, v;
      longint unsigned uv, ip, p, f, e, res;
      int layer;
      h = alt;
      w.clamped = 1'b0;
      if (h < 0) begin
         h = 0;
         w.clamped = 1'b1;
      end else if (h > 470000) begin
         h = 470000;
         w.clamped = 1'b1;
      end
      layer = 0;
      for (int j = 1; j < 4; j++) if (h >= layer_base[j]) layer = j;
      lp = log2_q30(64'd101325);
      for (int j = 0; j < layer; j++)
         lp -= longint'(pressure_drop(j, layer_base[j + 1] - layer_base[j]));
      dh = h - layer_base[layer];
      lp -= longint'(pressure_drop(layer, dh));
      lrt = log2_q30(64'd287058 * 64'(layer_temp[layer] + layer_lapse[layer] * dh))
            - log2_q30(64'd100000000);
      v = lp - lrt + longint'(iad_pkg::DENSITY_FRAC_BITS) * longint'(ONE);
      if (v < 0) begin
         res = 0;
      end else begin
         uv = 64'(v);
         ip = uv >> 30;
         if (ip >= 31) begin
            res = 64'h7FFFFFFF;
         end else begin
            p = (uv & MASK) * DEP;
            f = p & MASK;
            e = exp_grid[p >> 30] + (((exp_grid[(p >> 30) + 1] - exp_grid[p >> 30]) * f) >> 30);
            res = (ip >= 30) ? (e << (ip - 30)) : (e >> (30 - ip));
            if (res > 64'h7FFFFFFF) res = 64'h7FFFFFFF;
         end
      end
      w.density = res[iad_pkg::DENS_W-1:0];
      w.layer   = layer[iad_pkg::LAYER_W-1:0];
      awaited.push_back(w);
   endfunction

   // Compare one result word with the oldest prediction.
   function void check_density(logic [iad_pkg::DENS_W-1:0] density,
                               logic [iad_pkg::LAYER_W-1:0] layer, logic clamped);
      density_word w;
      if (awaited.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result word: density %0d layer %0d clamped %0b",
                     density, layer, clamped);
         return;
      end
      w = awaited.pop_front();
      checked++;
      if (clamped) clamp_seen++;
      layer_seen[layer]++;
      if (density !== w.density || layer !== w.layer || clamped !== w.clamped) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: density exp %0d got %0d, layer exp %0d got %0d, clamped exp %0b got %0b",
                     w.density, density, w.layer, layer, w.clamped, clamped);
      end
   endfunction
endclass

module isa_air_density_test;
   import iad_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [ALT_W-1:0]   req_altitude_dm;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [DENS_W-1:0]         rsp_density_q30;
   logic [LAYER_W-1:0]        rsp_layer_index;
   logic                      rsp_altitude_clamped;

   density_scoreboard board;
   bit                calm;
   bit                hold_request;
   int                sent;

   isa_air_density dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_altitude_dm(req_altitude_dm),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_density_q30(rsp_density_q30),
      .rsp_layer_index(rsp_layer_index), .rsp_altitude_clamped(rsp_altitude_clamped)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on run time.
   initial begin
      #3ms;
      $display("FAIL");
      $finish;
   end

   // Offer one altitude word, idling at random first, and wait for acceptance.
   task automatic send_altitude(logic signed [ALT_W-1:0] alt);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_altitude_dm <= alt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_altitude(alt);
      sent++;
   endtask

   // Random altitude, weighted toward the atmosphere and its layer boundaries.
   function automatic logic signed [ALT_W-1:0] pick_altitude();
      int r;
      int edges[6] = '{0, 110000, 200000, 320000, 470000, 1};
      r = $urandom_range(99);
      if (r < 50) return ALT_W'($urandom_range(470000));
      if (r < 75) return ALT_W'($urandom);
      return ALT_W'(edges[$urandom_range(4)] + $urandom_range(8) - 4);
   endfunction

   // Result side: random stalls, one long hold-off on request.
   initial begin
      int hold;
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold = 300;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 27);
         end
         @(negedge clock);
      end
   end

   // Check every accepted result word.
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         board.check_density(rsp_density_q30, rsp_layer_index, rsp_altitude_clamped);

   initial begin
      int wait_cycles;
      logic signed [ALT_W-1:0] directed[$];
      board           = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_altitude_dm = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Field extremes, clamping on both sides and every layer boundary.
      directed = '{-21'sd1048576, 21'sd1048575, -21'sd1000000, 21'sd1000000, -21'sd1,
                   21'sd0, 21'sd1, 21'sd109999, 21'sd110000, 21'sd110001, 21'sd199999,
                   21'sd200000, 21'sd200001, 21'sd319999, 21'sd320000, 21'sd320001,
                   21'sd469999, 21'sd470000, 21'sd470001, 21'sd55555, 21'sd400000};
      foreach (directed[i]) send_altitude(directed[i]);

      for (int n = 0; n < 1880; n++) begin
         calm = (n >= 1000 && n < 1250);
         if (n == 500) hold_request = 1'b1;
         send_altitude(pick_altitude());
      end
      calm = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain, then let the pipeline settle.
      wait_cycles = 0;
      while (board.awaited.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (40) @(posedge clock);

      $display("Sent %0d altitude words, checked %0d densities, %0d clamped.",
               sent, board.checked, board.clamp_seen);
      $display("Layers hit: %0d / %0d / %0d / %0d, mismatches %0d.", board.layer_seen[0],
               board.layer_seen[1], board.layer_seen[2], board.layer_seen[3], board.mismatches);
      if (board.mismatches == 0 && board.awaited.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
